// ===== rtl/msri_pkg.sv =====
// msri_pkg: shared types and constants of the motor speed ramp integrator
// no dependencies; used by the channel interfaces and the top level

package msri_pkg;

  // fixed-point position of speed and angle
  localparam int FRAC_BITS = 16;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ACCEL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND = 2'd3;

  localparam logic [15:0] ACCEL_RST     = 16'd12800;
  localparam logic [15:0] DECEL_RST     = 16'd6400;
  localparam logic [15:0] MAX_SPEED_RST = 16'd15360;
  localparam logic [14:0] DEAD_BAND_RST = 15'd8;

  // request kinds
  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  // direction codes
  localparam logic [1:0] DIR_IDLE = 2'd0;
  localparam logic [1:0] DIR_FWD  = 2'd1;
  localparam logic [1:0] DIR_REV  = 2'd2;

  // command full scale, Q2.14
  localparam logic [16:0] CMD_ONE = 17'd16384;

  // 180/pi in Q16
  localparam logic [21:0] DEG_PER_RAD = 22'd3754936;

  // shared multiplier
  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  // signed working width of the speed update
  localparam int SPD_W = 36;

  localparam int DRIVE_SHIFT = 38 - FRAC_BITS;
  localparam int COAST_SHIFT = 24 - FRAC_BITS;
  localparam int LIM_SHIFT   = FRAC_BITS - 8;
  localparam int ANG_SHIFT   = 16;
  localparam int DEG_SHIFT   = FRAC_BITS + 8;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] drive_command;
    logic        [15:0] time_step;
  } msri_in_t;

  typedef struct packed {
    logic signed [31:0] angle_radians;
    logic signed [31:0] angle_degrees;
    logic signed [31:0] speed_now;
    logic        [1:0]  motion_dir;
  } msri_out_t;

endpackage

// ===== rtl/msri_in_if.sv =====
// msri_in_if: request channel of the ramp integrator, valid/ready handshake
// depends on msri_pkg for the payload type

interface msri_in_if;
  import msri_pkg::*;

  logic     valid;
  logic     ready;
  msri_in_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/msri_out_if.sv =====
// msri_out_if: result channel of the ramp integrator, valid/ready handshake
// depends on msri_pkg for the payload type

interface msri_out_if;
  import msri_pkg::*;

  logic      valid;
  logic      ready;
  msri_out_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/motor_speed_ramp_integrator.sv =====
// motor_speed_ramp_integrator: velocity ramp, angle integration and degree conversion
// depends on msri_pkg, msri_in_if and msri_out_if
//
//  channel  | dir | handshake        | payload
//  in_chan  | in  | valid/ready      | kind, drive_command, time_step
//  out_chan | out | valid/ready      | angle_radians, angle_degrees, speed_now, motion_dir
//  cfg_*    | in  | cfg_we, no ready | cfg_index, cfg_data
//
// a coasting tick skips the command step of a driven tick and a clear skips the ramp and
// angle steps; multiplies run one after another on a single registered 32x32 multiplier
// in_chan.ready is high only while the sequencer idles
// a finished result sits in the output register; a new request is taken while
// it waits, and the next result waits in its last step until the slot frees
// rst_n is synchronous: speed, angle and direction clear, registers reload defaults

module motor_speed_ramp_integrator (
  input  logic                              clk,
  input  logic                              rst_n,
  msri_in_if.sink                           in_chan,
  msri_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [msri_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [msri_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import msri_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RATE  = 8'b0000_0010,
    S_CMD   = 8'b0000_0100,
    S_SPEED = 8'b0000_1000,
    S_ANGLE = 8'b0001_0000,
    S_ADD   = 8'b0010_0000,
    S_DEG   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0] accel_r, decel_r, max_speed_r;
  logic [14:0] dead_band_r;

  logic signed [31:0] speed_r, speed_nxt;
  logic        [31:0] angle_r, angle_nxt;
  logic        [1:0]  dir_r, dir_nxt;

  // per-request latches
  logic        drive_r;
  logic        cmd_neg_r;
  logic [14:0] cmd_mag_r;
  logic [15:0] dt_r;

  logic [MUL_W-1:0]  mul_a, mul_b;
  logic              mul_en;
  logic [PROD_W-1:0] prod_r;

  logic      out_valid_r, out_valid_nxt;
  msri_out_t out_data_r;

  logic accept;
  logic out_free;

  // command clamp and dead band
  logic [15:0] cmd_bits;
  logic        cmd_neg;
  logic [16:0] cmd_raw_mag;
  logic [14:0] cmd_mag;

  // speed update
  logic signed [SPD_W-1:0] spd_ext, delta_s, spd_upd, lim_s, spd_clamp;
  logic signed [SPD_W-1:0] spd_max;

  logic [31:0] spd_mag, ang_mag, step, deg_mag, deg_val;

  assign accept   = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  always_comb begin
    cmd_bits    = in_chan.data.drive_command;
    cmd_neg     = cmd_bits[15];
    cmd_raw_mag = cmd_neg ? ({1'b0, ~cmd_bits} + 17'd1) : {1'b0, cmd_bits};
    cmd_mag     = (cmd_raw_mag > CMD_ONE) ? CMD_ONE[14:0] : cmd_raw_mag[14:0];
  end

  // shared multiplier operand select
  always_comb begin
    spd_mag = speed_r[31] ? (~speed_r + 32'd1) : speed_r;
    ang_mag = angle_r[31] ? (~angle_r + 32'd1) : angle_r;
    mul_a   = '0;
    mul_b   = '0;
    mul_en  = 1'b1;
    unique case (state_r)
      S_RATE: begin
        mul_a = MUL_W'(drive_r ? accel_r : decel_r);
        mul_b = MUL_W'(dt_r);
      end
      S_CMD: begin
        mul_a = prod_r[MUL_W-1:0];
        mul_b = MUL_W'(cmd_mag_r);
      end
      S_ANGLE: begin
        mul_a = spd_mag;
        mul_b = MUL_W'(dt_r);
      end
      S_DEG: begin
        mul_a = ang_mag;
        mul_b = MUL_W'(DEG_PER_RAD);
      end
      S_IDLE, S_SPEED, S_ADD, S_OUT: begin
        mul_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
  end

  // speed ramp, coast and limit
  always_comb begin
    spd_ext = SPD_W'(speed_r);
    spd_max = SPD_W'(32'h7FFF_FFFF);
    if (drive_r) begin
      delta_s = SPD_W'(prod_r >> DRIVE_SHIFT);
      spd_upd = cmd_neg_r ? (spd_ext - delta_s) : (spd_ext + delta_s);
    end else begin
      delta_s = SPD_W'(prod_r >> COAST_SHIFT);
      if (spd_ext > 0) begin
        spd_upd = spd_ext - delta_s;
        if (spd_upd < 0) begin
          spd_upd = '0;
        end
      end else begin
        spd_upd = spd_ext + delta_s;
        if (spd_upd > 0) begin
          spd_upd = '0;
        end
      end
    end
    lim_s = SPD_W'(max_speed_r) << LIM_SHIFT;
    if (lim_s > spd_max) begin
      lim_s = spd_max;
    end
    if (spd_upd > lim_s) begin
      spd_clamp = lim_s;
    end else if (spd_upd < -lim_s) begin
      spd_clamp = -lim_s;
    end else begin
      spd_clamp = spd_upd;
    end
  end

  always_comb begin
    step    = prod_r[ANG_SHIFT +: 32];
    deg_mag = prod_r[DEG_SHIFT +: 32];
    deg_val = angle_r[31] ? (~deg_mag + 32'd1) : deg_mag;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    speed_nxt     = speed_r;
    angle_nxt     = angle_r;
    dir_nxt       = dir_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_chan.data.kind == KIND_CLEAR) begin
            speed_nxt = '0;
            angle_nxt = '0;
            state_nxt = S_DEG;
          end else begin
            state_nxt = S_RATE;
          end
        end
      end
      S_RATE: begin
        state_nxt = drive_r ? S_CMD : S_SPEED;
      end
      S_CMD: begin
        state_nxt = S_SPEED;
      end
      S_SPEED: begin
        speed_nxt = spd_clamp[31:0];
        dir_nxt   = !drive_r ? DIR_IDLE : (cmd_neg_r ? DIR_REV : DIR_FWD);
        state_nxt = S_ANGLE;
      end
      S_ANGLE: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        angle_nxt = angle_r + (speed_r[31] ? (~step + 32'd1) : step);
        state_nxt = S_DEG;
      end
      S_DEG: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      speed_r     <= '0;
      angle_r     <= '0;
      dir_r       <= DIR_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      speed_r     <= speed_nxt;
      angle_r     <= angle_nxt;
      dir_r       <= dir_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r     <= ACCEL_RST;
      decel_r     <= DECEL_RST;
      max_speed_r <= MAX_SPEED_RST;
      dead_band_r <= DEAD_BAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACCEL:     accel_r     <= cfg_data;
        REG_DECEL:     decel_r     <= cfg_data;
        REG_MAX_SPEED: max_speed_r <= cfg_data;
        REG_DEAD_BAND: dead_band_r <= cfg_data[14:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      drive_r   <= (cmd_mag > dead_band_r);
      cmd_neg_r <= cmd_neg;
      cmd_mag_r <= cmd_mag;
      dt_r      <= in_chan.data.time_step;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && out_free) begin
      out_data_r.angle_radians <= angle_r;
      out_data_r.angle_degrees <= deg_val;
      out_data_r.speed_now     <= speed_r;
      out_data_r.motion_dir    <= dir_r;
    end
  end

  // a request holds off the next one until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_chan.ready)
    else $error("request taken while previous one still in work");

  // a clear leaves speed and angle at zero
  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_chan.data.kind == KIND_CLEAR |=> speed_r == 0 && angle_r == 0)
    else $error("clear did not zero speed and angle");

  // speed never leaves the configured limit after an update
  a_speed_limit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ANGLE |-> (spd_ext <= lim_s) && (spd_ext >= -lim_s))
    else $error("speed outside limit");

  // a new result only comes from the final step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside final step");

endmodule

// ===== test/testbench.sv =====
// testbench: self-checking bench for motor_speed_ramp_integrator, with random
// stalls on both channels and a bit-accurate ramp and angle predictor
// depends on msri_pkg, msri_in_if, msri_out_if and the top level rtl

module testbench;
  import msri_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RX_HOLD_LEN    = 80;
  localparam int PHASE_ITEMS    = 225;

  class ramp_scoreboard;
    longint      accel, decel, vmax, dband;
    logic [31:0] speed, angle;
    logic [1:0]  dir;
    msri_out_t   expected_q[$];
    int          errors;

    function new();
      accel  = ACCEL_RST;
      decel  = DECEL_RST;
      vmax   = MAX_SPEED_RST;
      dband  = DEAD_BAND_RST;
      speed  = '0;
      angle  = '0;
      dir    = DIR_IDLE;
      errors = 0;
    endfunction

    function void set_regs(logic [15:0] a, logic [15:0] d, logic [15:0] m, logic [14:0] db);
      accel = a;
      decel = d;
      vmax  = m;
      dband = db;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // advance the shaft by one request and queue the result it must produce
    function void note_request(msri_in_t req);
      longint    cmd, dt, v, mag, lim, full, a, deg;
      msri_out_t res;
      if (req.kind == KIND_CLEAR) begin
        speed = '0;
        angle = '0;
      end else begin
        full = CMD_ONE;
        dt   = req.time_step;
        cmd  = req.drive_command;
        if (cmd > full) cmd = full;
        if (cmd < -full) cmd = -full;
        v = $signed(speed);
        if (cmd > dband || cmd < -dband) begin
          mag = (cmd < 0) ? -cmd : cmd;
          mag = (accel * dt * mag) >> DRIVE_SHIFT;
          v   = (cmd < 0) ? v - mag : v + mag;
          dir = (cmd < 0) ? DIR_REV : DIR_FWD;
        end else begin
          // coast toward zero, never past it
          dir = DIR_IDLE;
          mag = (decel * dt) >> COAST_SHIFT;
          if (v > 0) v = (v > mag) ? v - mag : 0;
          else v = (-v > mag) ? v + mag : 0;
        end
        lim = vmax << LIM_SHIFT;
        if (lim > 2147483647) lim = 2147483647;
        if (v > lim) v = lim;
        else if (v < -lim) v = -lim;
        speed = v[31:0];
        mag   = (((v < 0) ? -v : v) * dt) >> ANG_SHIFT;
        angle = 32'(angle + ((v < 0) ? -mag : mag));
      end
      a   = $signed(angle);
      deg = (((a < 0) ? -a : a) * DEG_PER_RAD) >> DEG_SHIFT;
      res.angle_radians = angle;
      res.angle_degrees = 32'((a < 0) ? -deg : deg);
      res.speed_now     = speed;
      res.motion_dir    = dir;
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("mismatch: %s", msg);
    endtask

    task check_result(msri_out_t got);
      msri_out_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected: %p", got));
        return;
      end
      want = expected_q.pop_front();
      if (got.angle_radians !== want.angle_radians)
        report($sformatf("angle_radians got %0d want %0d", got.angle_radians,
                         want.angle_radians));
      if (got.angle_degrees !== want.angle_degrees)
        report($sformatf("angle_degrees got %0d want %0d", got.angle_degrees,
                         want.angle_degrees));
      if (got.speed_now !== want.speed_now)
        report($sformatf("speed_now got %0d want %0d", got.speed_now, want.speed_now));
      if (got.motion_dir !== want.motion_dir)
        report($sformatf("motion_dir got %0d want %0d", got.motion_dir, want.motion_dir));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  msri_in_if  in_if();
  msri_out_if out_if();

  ramp_scoreboard sb = new();

  int tx_gap_pct;
  int rx_stall_pct;
  int hold_count;
  int hold_seen;
  int hold_left;
  int stall_left;
  int idle_cycles;

  motor_speed_ramp_integrator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    if ($urandom_range(99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      hold_seen = hold_count;
      hold_left = 0;
      stall_left = 0;
    end else begin
      if (hold_seen != hold_count) begin
        hold_seen = hold_count;
        hold_left = RX_HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if ($urandom_range(99) < rx_stall_pct) begin
        stall_left = idle_len() - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (in_if.valid && in_if.ready) sb.note_request(in_if.data);
    if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
    $display("testbench NOT OK");
    $finish;
  end

  task automatic send_item(msri_in_t req);
    int gap;
    in_if.valid <= 1'b1;
    in_if.data  <= req;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    gap = ($urandom_range(99) < tx_gap_pct) ? idle_len() : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_tick(int cmd, int dt);
    msri_in_t req;
    req.kind          = KIND_TICK;
    req.drive_command = 16'(cmd);
    req.time_step     = 16'(dt);
    send_item(req);
  endtask

  // clear carries garbage in the fields it ignores
  task automatic send_clear();
    msri_in_t req;
    req.kind          = KIND_CLEAR;
    req.drive_command = 16'($urandom);
    req.time_step     = 16'($urandom);
    send_item(req);
  endtask

  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_regs(logic [15:0] a, logic [15:0] d, logic [15:0] m, logic [14:0] db);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ACCEL;
    cfg_data  <= a;
    @(posedge clk);
    cfg_index <= REG_DECEL;
    cfg_data  <= d;
    @(posedge clk);
    cfg_index <= REG_MAX_SPEED;
    cfg_data  <= m;
    @(posedge clk);
    cfg_index <= REG_DEAD_BAND;
    cfg_data  <= {1'b0, db};
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_regs(a, d, m, db);
  endtask

  function automatic msri_in_t random_request();
    msri_in_t r;
    int       pick;
    int       c;
    r.kind          = ($urandom_range(99) < 5) ? KIND_CLEAR : KIND_TICK;
    r.drive_command = 16'($urandom);
    r.time_step     = 16'($urandom);
    pick = $urandom_range(99);
    if (pick < 25) begin
      // around the dead band edge
      c = int'(sb.dband + $urandom_range(2) - 1);
      r.drive_command = $urandom_range(1) ? 16'(-c) : 16'(c);
    end else if (pick < 40) begin
      case ($urandom_range(3))
        0: r.drive_command = 16'sh7FFF;
        1: r.drive_command = 16'sh8000;
        2: r.drive_command = 16'sd16384;
        default: r.drive_command = -16'sd16384;
      endcase
    end else if (pick < 55) begin
      r.drive_command = 16'($urandom_range(128) - 64);
    end
    pick = $urandom_range(99);
    if (pick < 10) r.time_step = 16'd0;
    else if (pick < 20) r.time_step = 16'hFFFF;
    else if (pick < 40) r.time_step = 16'($urandom_range(255));
    return r;
  endfunction

  initial begin
    int phase;
    int n;
    rst_n        <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= REG_ACCEL;
    cfg_data     <= '0;
    tx_gap_pct   <= 30;
    rx_stall_pct <= 30;
    hold_count   <= 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part at the reset register values
    send_clear();
    send_tick(0, 1000);
    send_tick(32767, 65535);
    send_tick(16384, 65535);
    send_tick(8, 20000);
    send_tick(-8, 20000);
    send_tick(9, 65535);
    send_tick(-9, 65535);
    send_tick(-32768, 65535);
    send_tick(-16384, 65535);
    send_tick(-16385, 65535);
    send_clear();
    send_tick(0, 0);
    send_tick(16384, 0);
    send_tick(20000, 30000);
    send_tick(0, 65535);
    send_tick(0, 65535);
    send_tick(0, 65535);
    send_tick(0, 65535);
    send_tick(-1, 1);
    send_tick(1, 65535);
    send_tick(-20000, 40000);
    send_clear();

    for (phase = 0; phase < 6; phase++) begin
      in_if.valid <= 1'b0;
      // let the monitor note the last request before checking the queue
      @(posedge clk);
      wait_drained();
      repeat (4) @(posedge clk);
      case (phase)
        0: write_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'd0);
        1: write_regs(16'd0, 16'd0, 16'd0, 15'd16384);
        2: write_regs(16'($urandom), 16'($urandom), 16'($urandom), 15'h7FFF);
        3: write_regs(16'd300, 16'd50, 16'hFFFF, 15'($urandom_range(200)));
        4: write_regs(16'($urandom), 16'($urandom), 16'($urandom_range(200, 65535)),
                      15'($urandom_range(16384)));
        default: write_regs(ACCEL_RST, DECEL_RST, MAX_SPEED_RST, DEAD_BAND_RST);
      endcase
      tx_gap_pct   <= (phase == 0) ? 0 : 35;
      rx_stall_pct <= (phase == 0) ? 0 : ((phase == 4) ? 60 : 30);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 3 && n == 100) hold_count <= hold_count + 1;
        if (phase == 2 && n == 150) begin
          in_if.valid <= 1'b0;
          @(posedge clk);
          wait_drained();
        end
        send_item(random_request());
      end
    end

    in_if.valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (16) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
